>>> rtl/pid_pkg.sv
package pid_pkg;

   // Field widths
   localparam int DATA_W  = 32;               // Q16.16 words
   localparam int STEP_W  = 24;               // Q8.16 time step
   localparam int LIMIT_W = 31;               // integral bound
   localparam int ADDR_W  = 4;                // register index
   localparam int OPND_W  = DATA_W + 1;       // shared multiplier operand
   localparam int PROD_W  = 2 * OPND_W;       // shared multiplier product
   localparam int FRAC_W  = 16;
   localparam int TERM_W  = PROD_W - FRAC_W;  // product after the Q16 shift
   localparam int ACC_W   = TERM_W + 2;       // sum of three terms
   localparam int NUM_W   = 50;               // dividend, even bit count
   localparam int REM_W   = STEP_W;
   localparam int DIV_STEPS = NUM_W / 2;      // two quotient bits a cycle
   localparam int CNT_W   = $clog2(DIV_STEPS);

   // Saturation bounds
   localparam logic signed [ACC_W-1:0] CMD_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] CMD_MIN = ACC_W'(-64'sd2147483648);
   localparam logic [NUM_W-1:0] QPOS_MAX = NUM_W'(64'd2147483647);
   localparam logic [NUM_W-1:0] QNEG_MAX = NUM_W'(64'd2147483648);

   typedef enum logic [ADDR_W-1:0] {
      REG_PROP_GAIN   = 4'd0,
      REG_INTEG_GAIN  = 4'd1,
      REG_DERIV_GAIN  = 4'd2,
      REG_INTEG_LIMIT = 4'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_INT,
      ST_INTEG,
      ST_DIV,
      ST_DERIV,
      ST_TERM_P,
      ST_TERM_I,
      ST_TERM_D,
      ST_RESULT
   } state_type;

   // Divide a product by 2^16, truncating toward zero
   function automatic logic signed [TERM_W-1:0] trunc_q16(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] biased;
      biased = p + (p[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
      return biased[PROD_W-1:FRAC_W];
   endfunction

endpackage

>>> rtl/pid_if.sv
interface pid_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [pid_pkg::DATA_W-1:0] error_sample;
   logic        [pid_pkg::STEP_W-1:0] time_step;

   modport source (output valid, output error_sample, output time_step, input ready);
   modport sink   (input valid, input error_sample, input time_step, output ready);
endinterface

interface pid_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pid_pkg::DATA_W-1:0] command;
   logic                              saturated;

   modport source (output valid, output command, output saturated, input ready);
   modport sink   (input valid, input command, input saturated, output ready);
endinterface

interface pid_csr_if;
   logic                              valid;
   logic                              ready;
   logic        [pid_pkg::ADDR_W-1:0] index;
   logic        [pid_pkg::DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/pid_step_with_integral_clamp.sv
// PID step with a clamped integral, signed Q16.16.
// req_bus takes one word: an error sample and a Q8.16 time step. rsp_bus gives
// one word per request: the saturated command and a saturation flag.
// csr_bus writes the gains (index 0..2) and the integral bound (index 3); it is
// always ready, and a write to a known index clears the integral, the stored
// error and the history flag. Write only while no request is in flight.
// One shared 33x33 multiplier and a radix-4 restoring divider (which forms
// the derivative quotient) run under a small sequencer. Each request is
// worked to the end before the next request is taken. Without history
// (first step) the divider is skipped. A zero time step answers with zero
// and changes no state.
// req_bus.ready is high only while the sequencer is idle.
// The response sits in an output register; while the receiver stalls the
// block still takes and works the next request, and holds it at the end
// until the output register frees up.
// Reset (synchronous, active high) zeroes gains, bound and history and
// empties the output register.
module pid_step_with_integral_clamp (
   input  logic           clock,
   input  logic           reset,
   pid_req_if.sink        req_bus,
   pid_rsp_if.source      rsp_bus,
   pid_csr_if.sink        csr_bus
);

   // Control state
   pid_pkg::state_type                  state_ff, state_in;
   logic [pid_pkg::CNT_W-1:0]           cnt_ff, cnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // Configuration
   logic signed [pid_pkg::DATA_W-1:0]   kp_ff, kp_in;
   logic signed [pid_pkg::DATA_W-1:0]   ki_ff, ki_in;
   logic signed [pid_pkg::DATA_W-1:0]   kd_ff, kd_in;
   logic [pid_pkg::LIMIT_W-1:0]         limit_ff, limit_in;

   // History
   logic signed [pid_pkg::DATA_W-1:0]   integral_ff, integral_in;
   logic signed [pid_pkg::DATA_W-1:0]   last_err_ff, last_err_in;
   logic                                hist_ff, hist_in;

   // Working registers
   logic signed [pid_pkg::DATA_W-1:0]   err_ff, err_in;
   logic [pid_pkg::STEP_W-1:0]          dt_ff, dt_in;
   logic [pid_pkg::NUM_W-1:0]           qn_ff, qn_in;
   logic [pid_pkg::REM_W-1:0]           rem_ff, rem_in;
   logic                                neg_ff, neg_in;
   logic signed [pid_pkg::DATA_W-1:0]   deriv_ff, deriv_in;
   logic signed [pid_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic                                sat_ff, sat_in;
   logic signed [pid_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [pid_pkg::DATA_W-1:0]   cmd_ff, cmd_in;
   logic                                flag_ff, flag_in;

   // Shared multiplier operands
   logic signed [pid_pkg::OPND_W-1:0]   mul_a, mul_b;

   logic req_acc, csr_acc, out_free;

   assign req_bus.ready = (state_ff == pid_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_acc  = req_bus.valid & req_bus.ready;
   assign csr_acc  = csr_bus.valid & csr_bus.ready;
   assign out_free = ~rsp_valid_ff | rsp_bus.ready;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.command   = cmd_ff;
   assign rsp_bus.saturated = flag_ff;

   // Select multiplier operands by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         pid_pkg::ST_MUL_INT: begin
            mul_a = {err_ff[pid_pkg::DATA_W-1], err_ff};
            mul_b = $signed({{(pid_pkg::OPND_W-pid_pkg::STEP_W){1'b0}}, dt_ff});
         end
         pid_pkg::ST_DERIV: begin
            mul_a = {kp_ff[pid_pkg::DATA_W-1], kp_ff};
            mul_b = {err_ff[pid_pkg::DATA_W-1], err_ff};
         end
         pid_pkg::ST_TERM_P: begin
            mul_a = {ki_ff[pid_pkg::DATA_W-1], ki_ff};
            mul_b = {integral_ff[pid_pkg::DATA_W-1], integral_ff};
         end
         pid_pkg::ST_TERM_I: begin
            mul_a = {kd_ff[pid_pkg::DATA_W-1], kd_ff};
            mul_b = {deriv_ff[pid_pkg::DATA_W-1], deriv_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Sequencer: next state and datapath updates
   always_comb begin
      logic signed [pid_pkg::TERM_W-1:0]   term;
      logic signed [pid_pkg::TERM_W-1:0]   sum_int;
      logic signed [pid_pkg::TERM_W-1:0]   lim_pos;
      logic signed [pid_pkg::DATA_W:0]     diff;
      logic [pid_pkg::DATA_W:0]            mag;
      logic [pid_pkg::REM_W:0]             r_wide;
      logic [pid_pkg::REM_W-1:0]           r_cur;
      logic [pid_pkg::NUM_W-1:0]           q_cur;
      logic signed [pid_pkg::ACC_W-1:0]    acc_sum;

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      kp_in        = kp_ff;
      ki_in        = ki_ff;
      kd_in        = kd_ff;
      limit_in     = limit_ff;
      integral_in  = integral_ff;
      last_err_in  = last_err_ff;
      hist_in      = hist_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      qn_in        = qn_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      deriv_in     = deriv_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      cmd_in       = cmd_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;

      term    = pid_pkg::trunc_q16(prod_ff);
      acc_sum = acc_ff + {{(pid_pkg::ACC_W-pid_pkg::TERM_W){term[pid_pkg::TERM_W-1]}}, term};
      sum_int = {{(pid_pkg::TERM_W-pid_pkg::DATA_W){integral_ff[pid_pkg::DATA_W-1]}},
                 integral_ff} + term;
      lim_pos = $signed({{(pid_pkg::TERM_W-pid_pkg::LIMIT_W){1'b0}}, limit_ff});
      diff    = {err_ff[pid_pkg::DATA_W-1], err_ff} -
                {last_err_ff[pid_pkg::DATA_W-1], last_err_ff};
      mag     = diff[pid_pkg::DATA_W] ? $unsigned(-diff) : $unsigned(diff);
      r_cur   = rem_ff;
      q_cur   = qn_ff;
      r_wide  = '0;

      case (state_ff)
         pid_pkg::ST_IDLE: begin
            // Latch the word; a zero time step goes straight to a zero answer
            if (req_acc) begin
               err_in = req_bus.error_sample;
               dt_in  = req_bus.time_step;
               acc_in = '0;
               sat_in = 1'b0;
               state_in = (req_bus.time_step == '0) ? pid_pkg::ST_RESULT
                                                    : pid_pkg::ST_MUL_INT;
            end
         end
         pid_pkg::ST_MUL_INT: begin
            state_in = pid_pkg::ST_INTEG;
         end
         pid_pkg::ST_INTEG: begin
            // Add the increment, clamp, and load the divider
            if (sum_int > lim_pos) begin
               integral_in = lim_pos[pid_pkg::DATA_W-1:0];
            end else if (sum_int < -lim_pos) begin
               integral_in = pid_pkg::DATA_W'(-lim_pos);
            end else begin
               integral_in = sum_int[pid_pkg::DATA_W-1:0];
            end
            neg_in      = hist_ff & diff[pid_pkg::DATA_W];
            qn_in       = hist_ff ? {1'b0, mag, {pid_pkg::FRAC_W{1'b0}}} : '0;
            rem_in      = '0;
            cnt_in      = pid_pkg::CNT_W'(pid_pkg::DIV_STEPS - 1);
            last_err_in = err_ff;
            hist_in     = 1'b1;
            state_in    = hist_ff ? pid_pkg::ST_DIV : pid_pkg::ST_DERIV;
         end
         pid_pkg::ST_DIV: begin
            // Two restoring steps a cycle; quotient bits shift in at the bottom
            for (int k = 0; k < 2; k++) begin
               r_wide = {r_cur, q_cur[pid_pkg::NUM_W-1]};
               q_cur  = {q_cur[pid_pkg::NUM_W-2:0], 1'b0};
               if (r_wide >= {1'b0, dt_ff}) begin
                  r_wide   = r_wide - {1'b0, dt_ff};
                  q_cur[0] = 1'b1;
               end
               r_cur = r_wide[pid_pkg::REM_W-1:0];
            end
            rem_in = r_cur;
            qn_in  = q_cur;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = pid_pkg::ST_DERIV;
            end
         end
         pid_pkg::ST_DERIV: begin
            // Saturate the signed quotient to 32 bits
            if (neg_ff) begin
               if (qn_ff > pid_pkg::QNEG_MAX) begin
                  deriv_in = $signed(pid_pkg::QNEG_MAX[pid_pkg::DATA_W-1:0]);
                  sat_in   = 1'b1;
               end else begin
                  deriv_in = -$signed(qn_ff[pid_pkg::DATA_W-1:0]);
               end
            end else begin
               if (qn_ff > pid_pkg::QPOS_MAX) begin
                  deriv_in = $signed(pid_pkg::QPOS_MAX[pid_pkg::DATA_W-1:0]);
                  sat_in   = 1'b1;
               end else begin
                  deriv_in = $signed(qn_ff[pid_pkg::DATA_W-1:0]);
               end
            end
            state_in = pid_pkg::ST_TERM_P;
         end
         pid_pkg::ST_TERM_P: begin
            acc_in   = acc_sum;
            state_in = pid_pkg::ST_TERM_I;
         end
         pid_pkg::ST_TERM_I: begin
            acc_in   = acc_sum;
            state_in = pid_pkg::ST_TERM_D;
         end
         pid_pkg::ST_TERM_D: begin
            acc_in   = acc_sum;
            state_in = pid_pkg::ST_RESULT;
         end
         pid_pkg::ST_RESULT: begin
            // Hold until the output register frees up, then saturate and send
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (acc_ff > pid_pkg::CMD_MAX) begin
                  cmd_in  = pid_pkg::CMD_MAX[pid_pkg::DATA_W-1:0];
                  flag_in = 1'b1;
               end else if (acc_ff < pid_pkg::CMD_MIN) begin
                  cmd_in  = pid_pkg::CMD_MIN[pid_pkg::DATA_W-1:0];
                  flag_in = 1'b1;
               end else begin
                  cmd_in  = acc_ff[pid_pkg::DATA_W-1:0];
                  flag_in = sat_ff;
               end
               state_in = pid_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pid_pkg::ST_IDLE;
         end
      endcase

      // Register writes; a known index also clears the history
      if (csr_acc) begin
         case (csr_bus.index)
            pid_pkg::REG_PROP_GAIN: begin
               kp_in = $signed(csr_bus.data);
               integral_in = '0;
               last_err_in = '0;
               hist_in     = 1'b0;
            end
            pid_pkg::REG_INTEG_GAIN: begin
               ki_in = $signed(csr_bus.data);
               integral_in = '0;
               last_err_in = '0;
               hist_in     = 1'b0;
            end
            pid_pkg::REG_DERIV_GAIN: begin
               kd_in = $signed(csr_bus.data);
               integral_in = '0;
               last_err_in = '0;
               hist_in     = 1'b0;
            end
            pid_pkg::REG_INTEG_LIMIT: begin
               limit_in = csr_bus.data[pid_pkg::LIMIT_W-1:0];
               integral_in = '0;
               last_err_in = '0;
               hist_in     = 1'b0;
            end
            default: begin
               hist_in = hist_in;
            end
         endcase
      end
   end

   // Control, configuration and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pid_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         limit_ff     <= '0;
         integral_ff  <= '0;
         last_err_ff  <= '0;
         hist_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         limit_ff     <= limit_in;
         integral_ff  <= integral_in;
         last_err_ff  <= last_err_in;
         hist_ff      <= hist_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      dt_ff    <= dt_in;
      qn_ff    <= qn_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      deriv_ff <= deriv_in;
      acc_ff   <= acc_in;
      sat_ff   <= sat_in;
      prod_ff  <= prod_in;
      cmd_ff   <= cmd_in;
      flag_ff  <= flag_in;
   end

   // The stored integral never leaves the bound
   a_integral_bound: assert property (@(posedge clock) disable iff (reset)
      ($signed({integral_ff[pid_pkg::DATA_W-1], integral_ff}) <=
       $signed({2'b00, limit_ff})) &&
      ($signed({integral_ff[pid_pkg::DATA_W-1], integral_ff}) >=
       -$signed({2'b00, limit_ff})))
      else $error("integral outside its bound");

   // A response appears only out of the result step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pid_pkg::ST_RESULT))
      else $error("response raised outside the result step");

   // A zero time step skips all arithmetic with a cleared sum
   a_zero_step: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_bus.time_step == '0)) |=>
      ((state_ff == pid_pkg::ST_RESULT) && (acc_ff == '0) && !sat_ff))
      else $error("zero time step not short-cut");

   // The divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pid_pkg::ST_DERIV) |-> (rem_ff < dt_ff))
      else $error("divider remainder not below divisor");

endmodule
